>>> rtl/lbbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbf_pkg
// Shared types, constants and helpers of the link bitmap broadcast fan-out.
// ----------------------------------------------------------------------------
package lbbf_pkg;

  localparam int unsigned NODES = 32;    // nodes in use, 2 to 32
  localparam int unsigned NodeW = 5;     // node index width
  localparam int unsigned Rows  = 32;    // addressable nodes, 2**NodeW
  localparam int unsigned FuncW = 2;

  localparam logic [FuncW-1:0] FUNC_REMOVE = 2'd0;
  localparam logic [FuncW-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FuncW-1:0] FUNC_BCAST  = 2'd2;

  typedef enum logic [1:0] {
    OP_REMOVE,
    OP_ADD,
    OP_BCAST
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } st_e;

  typedef struct packed {
    op_e              op;
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
    logic [Rows-1:0]  up;
  } cmd_t;

  function automatic logic node_ok(logic [NodeW-1:0] n);
    return (32'(n) < 32'(NODES));
  endfunction

  function automatic logic [Rows-1:0] node_mask();
    logic [Rows-1:0] m;
    for (int k = 0; k < Rows; k++) begin
      m[k] = (32'(k) < 32'(NODES));
    end
    return m;
  endfunction

  // index of the lowest set bit, zero for an empty word
  function automatic logic [NodeW-1:0] lowest_bit(logic [Rows-1:0] v);
    logic [NodeW-1:0] idx;
    idx = '0;
    for (int k = Rows - 1; k >= 0; k--) begin
      if (v[k]) begin
        idx = NodeW'(k);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/lbbf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbf_front
// Takes input beats, decodes the function and drops items with no effect.
// ----------------------------------------------------------------------------
module lbbf_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lbbf_pkg::FuncW-1:0]     func_i,
  input  logic [lbbf_pkg::NodeW-1:0]     src_i,
  input  logic [lbbf_pkg::NodeW-1:0]     dst_i,
  input  logic [lbbf_pkg::Rows-1:0]      up_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output lbbf_pkg::cmd_t                 cmd_o
);

  logic           cmd_valid_q, cmd_valid_d;
  lbbf_pkg::cmd_t cmd_q, cmd_d;
  lbbf_pkg::cmd_t dec;
  logic           keep;
  logic           accept;

  assign in_ready_o = !cmd_valid_q || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    dec.src = src_i;
    dec.dst = dst_i;
    dec.up  = up_i & lbbf_pkg::node_mask();
    dec.op  = lbbf_pkg::OP_REMOVE;
    keep    = 1'b0;
    case (func_i)
      lbbf_pkg::FUNC_REMOVE: begin
        dec.op = lbbf_pkg::OP_REMOVE;
        keep   = lbbf_pkg::node_ok(src_i) && lbbf_pkg::node_ok(dst_i);
      end
      lbbf_pkg::FUNC_ADD: begin
        dec.op = lbbf_pkg::OP_ADD;
        keep   = lbbf_pkg::node_ok(src_i) && lbbf_pkg::node_ok(dst_i);
      end
      lbbf_pkg::FUNC_BCAST: begin
        dec.op = lbbf_pkg::OP_BCAST;
        keep   = 1'b1;
        // an out-of-range source sees no targets
        if (!lbbf_pkg::node_ok(src_i)) begin
          dec.up = '0;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    cmd_d       = cmd_q;
    if (accept) begin
      cmd_valid_d = keep;
      cmd_d       = dec;
    end else if (cmd_ready_i) begin
      cmd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> rtl/lbbf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbf_fifo
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module lbbf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lbbf_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output lbbf_pkg::cmd_t pop_data_o
);

  lbbf_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 2'd1))
    else $error("pop did not shrink queue");

endmodule

>>> rtl/lbbf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbf_back
// Holds the link matrix, applies updates and walks broadcast targets.
// ----------------------------------------------------------------------------
module lbbf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  lbbf_pkg::cmd_t             cmd_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [lbbf_pkg::NodeW-1:0] out_dest_o,
  output logic                       out_found_o,
  output logic                       out_last_o
);

  logic [lbbf_pkg::Rows-1:0] link_q [lbbf_pkg::Rows];

  lbbf_pkg::st_e             state_q, state_d;
  logic [lbbf_pkg::Rows-1:0] hits_q, hits_d;
  logic                      none_q, none_d;
  logic                      out_valid_q, out_valid_d;
  logic [lbbf_pkg::NodeW-1:0] dest_q, dest_d;
  logic                      found_q, found_d;
  logic                      last_q, last_d;

  logic                      take;
  logic                      slot_free;
  logic                      emit;
  logic                      upd;
  logic [lbbf_pkg::Rows-1:0] row_hits;
  logic [lbbf_pkg::NodeW-1:0] low;
  logic [lbbf_pkg::Rows-1:0] rest;

  assign slot_free = !out_valid_q || out_ready_i;
  assign take      = cmd_valid_i && cmd_ready_o;
  assign upd       = take && (cmd_i.op != lbbf_pkg::OP_BCAST);
  assign row_hits  = link_q[cmd_i.src] & cmd_i.up;
  assign low       = lbbf_pkg::lowest_bit(hits_q);
  assign rest      = hits_q & ~(lbbf_pkg::Rows'(1) << low);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lbbf_pkg::ST_IDLE: begin
        if (take && cmd_i.op == lbbf_pkg::OP_BCAST) begin
          state_d = lbbf_pkg::ST_WALK;
        end
      end
      lbbf_pkg::ST_WALK: begin
        if (slot_free && (none_q || rest == '0)) begin
          state_d = lbbf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lbbf_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_ready_o = 1'b0;
    emit        = 1'b0;
    hits_d      = hits_q;
    none_d      = none_q;
    case (state_q)
      lbbf_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        // always ready here, so a valid command is taken
        if (cmd_valid_i && cmd_i.op == lbbf_pkg::OP_BCAST) begin
          hits_d = row_hits;
          none_d = (row_hits == '0);
        end
      end
      lbbf_pkg::ST_WALK: begin
        emit = slot_free;
        if (slot_free) begin
          hits_d = none_q ? '0 : rest;
        end
      end
      default: begin
        cmd_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    dest_d      = dest_q;
    found_d     = found_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      dest_d      = none_q ? '0 : low;
      found_d     = !none_q;
      last_d      = none_q || (rest == '0);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbbf_pkg::ST_IDLE;
      hits_q      <= '0;
      none_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hits_q      <= hits_d;
      none_q      <= none_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q  <= dest_d;
    found_q <= found_d;
    last_q  <= last_d;
  end

  // link matrix, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < lbbf_pkg::Rows; r++) begin
        link_q[r] <= '0;
      end
    end else if (upd) begin
      link_q[cmd_i.src][cmd_i.dst] <= (cmd_i.op == lbbf_pkg::OP_ADD);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dest_o  = dest_q;
  assign out_found_o = found_q;
  assign out_last_o  = last_q;

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lbbf_pkg::ST_IDLE) |-> (hits_q == '0))
    else $error("target set left over after walk");

  a_walk_has_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lbbf_pkg::ST_WALK && !none_q) |-> (hits_q != '0))
    else $error("walking with no targets left");

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (last_q && dest_q == '0))
    else $error("no-target beat not final");

  a_no_take_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lbbf_pkg::ST_WALK) |-> !take)
    else $error("command taken during walk");

endmodule

>>> rtl/link_bitmap_broadcast_fanout_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_bitmap_broadcast_fanout_top
// Directed link bitmap with broadcast fan-out over a stream interface.
// ----------------------------------------------------------------------------
// Input beats carry a function in tuser: remove link, add link or broadcast.
// Add and remove set or clear bit (src, dst) of a 32 x 32 link matrix and
// give no output. A broadcast gives one output beat per linked destination
// that is also up in the supplied mask, in ascending node order, with tlast
// on the final one; with no target a single beat with found clear is sent.
// Function code 3 and updates naming nodes beyond NODES are dropped.
// Path: an input beat is registered in the front, queued, then taken by
// the back, which registers its target set and then each output beat.
// Throughput: the front takes one beat per cycle while the two-entry queue
// has room. The back applies a link update as it takes it; during a
// broadcast it takes no new command until all results have been sent.
// Reset clears the whole link matrix at once; no links exist afterwards.
// A stall on the master side holds the output register; the back stops
// walking, the queue fills and s_axis_tready_o then drops.
// ----------------------------------------------------------------------------
module link_bitmap_broadcast_fanout_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // src_node, dst_node, node_up_mask, zero pad
  input  logic [1:0]  s_axis_tuser_i,   // func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // dest_node, zero pad
  output logic        m_axis_tuser_o,   // found
  output logic        m_axis_tlast_o    // last
);

  logic           f_valid, f_ready;
  lbbf_pkg::cmd_t f_cmd;
  logic           b_valid, b_ready;
  lbbf_pkg::cmd_t b_cmd;
  logic [lbbf_pkg::NodeW-1:0] dest;

  lbbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .func_i      (s_axis_tuser_i),
    .src_i       (s_axis_tdata_i[4:0]),
    .dst_i       (s_axis_tdata_i[9:5]),
    .up_i        (s_axis_tdata_i[41:10]),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  lbbf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  lbbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_dest_o  (dest),
    .out_found_o (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, dest};

endmodule
